// ===== sv/erd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erd_pkg
// shared constants, types and helpers of the escape run-length byte decoder
// ----------------------------------------------------------------------------
package erd_pkg;

   // counter width of the produced byte count
   localparam int CNT_W   = 24;
   localparam int TOT_W   = 24;
   localparam int LIM_W   = 24;
   localparam int CMP_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam int RATIO_W = LIM_W + 10;
   localparam int IDX_W   = 2;

   localparam logic [7:0]         ESC_BYTE  = 8'hfe;
   localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(1000);
   localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [TOT_W-1:0]   TOT_MAX   = {TOT_W{1'b1}};

   // register indexes
   localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd0;
   localparam logic [IDX_W-1:0] REG_INPUT_LENGTH = 2'd1;
   localparam logic [IDX_W-1:0] REG_SKIP_COUNT   = 2'd2;

   // decoder phases
   localparam logic [1:0] PH_LIT = 2'd0;
   localparam logic [1:0] PH_VAL = 2'd1;
   localparam logic [1:0] PH_CNT = 2'd2;

   // final status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNC_ESC = 2'd1;
   localparam logic [1:0] ST_SHORT     = 2'd2;
   localparam logic [1:0] ST_RATIO     = 2'd3;

   typedef struct packed {
      logic [LIM_W-1:0] output_limit;
      logic [LIM_W-1:0] input_length;
      logic [7:0]       skip_count;
   } cfg_type;

   typedef struct packed {
      logic       last;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic             run_valid;
      logic [7:0]       run_value;
      logic [7:0]       run_length;
      logic             done_res;
      logic [1:0]       status;
      logic [TOT_W-1:0] produced_total;
   } result_type;

   // produced count as seen on the port, capped at the port width
   function automatic logic [TOT_W-1:0] sat_total(input logic [CNT_W-1:0] count);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(count);
      if (wide > CMP_W'(TOT_MAX)) begin
         return TOT_MAX;
      end
      return wide[TOT_W-1:0];
   endfunction

endpackage : erd_pkg
`default_nettype wire

// ===== sv/erd_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erd_csr
// configuration registers: output limit, input length, header skip count
// ----------------------------------------------------------------------------
module erd_csr import erd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [LIM_W-1:0] csr_data,
   output      cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_OUTPUT_LIMIT: cfg_in.output_limit = csr_data;
            REG_INPUT_LENGTH: cfg_in.input_length = csr_data;
            REG_SKIP_COUNT:   cfg_in.skip_count   = csr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_limit <= '0;
         cfg_ff.input_length <= '0;
         cfg_ff.skip_count   <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule : erd_csr
`default_nettype wire

// ===== sv/erd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erd_core
// stream state and the single-pass decode of one registered item
// ----------------------------------------------------------------------------
module erd_core import erd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   logic [1:0]       phase_ff,   phase_in;
   logic [7:0]       held_ff,    held_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic [7:0]       skipped_ff, skipped_in;
   logic             stopped_ff, stopped_in;

   logic               lim_on;
   logic [CMP_W-1:0]   limit_w;
   logic [CMP_W-1:0]   count_w;
   logic [CMP_W-1:0]   rem;
   logic [7:0]         clipped;
   logic [CNT_W:0]     sum;
   logic [RATIO_W-1:0] ratio_prod;
   logic               ratio_fail;
   logic [1:0]         phase_eff;
   logic               stop_eff;
   logic [7:0]         add_n;
   logic               do_add;

   assign lim_on     = (cfg.output_limit != '0);
   assign limit_w    = CMP_W'(cfg.output_limit);
   assign count_w    = CMP_W'(count_ff);
   assign rem        = (count_w < limit_w) ? (limit_w - count_w) : '0;
   assign clipped    = (lim_on && (CMP_W'(item.data_byte) > rem)) ? rem[7:0] : item.data_byte;
   assign ratio_prod = RATIO_W'(cfg.input_length) * RATIO_MAX;
   assign ratio_fail = lim_on && (RATIO_W'(cfg.output_limit) > ratio_prod);
   assign phase_eff  = ((phase_ff == PH_VAL) || (phase_ff == PH_CNT)) ? phase_ff : PH_LIT;
   // limit check happens only at the start of a token
   assign stop_eff   = stopped_ff
                     || ((phase_eff == PH_LIT) && lim_on && (count_w >= limit_w));
   assign sum        = {1'b0, count_ff} + (CNT_W+1)'(add_n);

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      skipped_in = skipped_ff;
      stopped_in = stopped_ff;
      add_n      = '0;
      do_add     = 1'b0;
      result     = '0;

      if (skipped_ff < cfg.skip_count) begin
         skipped_in = skipped_ff + 8'd1;
      end else begin
         phase_in   = phase_eff;
         stopped_in = stop_eff;
         if (!stop_eff) begin
            case (phase_eff)
               PH_VAL: begin
                  held_in  = item.data_byte;
                  phase_in = PH_CNT;
               end
               PH_CNT: begin
                  add_n             = clipped;
                  do_add            = 1'b1;
                  result.run_value  = held_ff;
                  result.run_length = clipped;
                  phase_in          = PH_LIT;
               end
               default: begin
                  if (item.data_byte == ESC_BYTE) begin
                     phase_in = PH_VAL;
                  end else begin
                     add_n             = 8'd1;
                     do_add            = 1'b1;
                     result.run_value  = item.data_byte;
                     result.run_length = 8'd1;
                  end
               end
            endcase
         end
      end

      count_in = count_ff;
      if (do_add) begin
         count_in = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      end

      result.run_valid = (result.run_length != 8'd0);
      if (!result.run_valid) begin
         result.run_value = 8'd0;
      end
      result.done_res       = item.last;
      result.produced_total = sat_total(count_in);

      if (item.last) begin
         if (ratio_fail) begin
            result.status = ST_RATIO;
         end else if ((phase_in == PH_VAL) || (phase_in == PH_CNT)) begin
            result.status = ST_TRUNC_ESC;
         end else if (lim_on && (CMP_W'(count_in) != limit_w)) begin
            result.status = ST_SHORT;
         end else begin
            result.status = ST_OK;
         end
         // stream state back to its start values
         phase_in   = PH_LIT;
         held_in    = 8'd0;
         count_in   = '0;
         skipped_in = 8'd0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LIT;
         held_ff    <= 8'd0;
         count_ff   <= '0;
         skipped_ff <= 8'd0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         count_ff   <= count_in;
         skipped_ff <= skipped_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule : erd_core
`default_nettype wire

// ===== sv/escape_rle_byte_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_rle_byte_decoder_top
// escape-coded run-length byte decoder, one compressed byte in, one result out
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  req      | in        | req_tvalid/req_tready  | tdata: data_byte, tlast: last
//  rsp      | out       | rsp_tvalid/rsp_tready  | tdata: value,length,status,total
//           |           |                        | tuser: run_valid, tlast: done
//  csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
//  one item per cycle sustained while rsp_tready is high; a taken item is held
//  in the input register, decoded, and its result is then offered from the
//  result register, where it can leave when rsp_tready is high
//  reset is synchronous and active high; no clearing pass, ready right after
//  a stalled result holds while the input register still takes one more item
//  csr_ready is always high; the user must see that registers are written between streams
// ----------------------------------------------------------------------------
module escape_rle_byte_decoder_top import erd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // request stream
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] data_byte
   input  wire logic             req_tlast,
   // result stream
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [47:0]      rsp_tdata,   // [7:0] run_value, [15:8] run_length,
                                              // [17:16] status, [41:18] produced_total
   output      logic [0:0]       rsp_tuser,   // [0] run_valid
   output      logic             rsp_tlast,   // done_res
   // configuration writes
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [LIM_W-1:0] csr_data
);

   cfg_type    cfg;
   item_type   item_ff,    item_in;
   logic       in_vld_ff,  in_vld_in;
   result_type res_ff,     res_in;
   result_type res_comb;
   logic       out_vld_ff, out_vld_in;
   logic       advance;
   logic       req_take;

   erd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   erd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_comb)
   );

   // decode moves on when an item is held and the result register is free or being drained
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in   = item_ff;
      in_vld_in = in_vld_ff;
      if (req_take) begin
         item_in.data_byte = req_tdata;
         item_in.last      = req_tlast;
         in_vld_in         = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      res_in     = res_ff;
      out_vld_in = out_vld_ff;
      if (advance) begin
         res_in     = res_comb;
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, res_ff.produced_total, res_ff.status,
                        res_ff.run_length, res_ff.run_value};
   assign rsp_tuser  = res_ff.run_valid;
   assign rsp_tlast  = res_ff.done_res;

endmodule : escape_rle_byte_decoder_top
`default_nettype wire

// ===== sv/erd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erd_checker
// port-level checks of the decoder result stream
// ----------------------------------------------------------------------------
module erd_checker import erd_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no run means zero value and zero length
   a_no_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[15:0] == 16'd0))
      else $error("empty result carries value or length");

   // a run always has a nonzero length
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[15:8] != 8'd0))
      else $error("run flagged with zero length");

   // status only on the last result of a stream
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[17:16] == ST_OK))
      else $error("status set before end of stream");

endmodule : erd_checker

bind escape_rle_byte_decoder_top erd_checker u_erd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== tb/tb_escape_rle_byte_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_rle_byte_decoder_top
// self-checking bench for the escape-coded run-length byte decoder: a queue-fed
// driver offers compressed bytes with random gaps, a monitor takes results with
// random stalls, and an in-bench decoder predicts every result of every item
// ----------------------------------------------------------------------------
module tb_escape_rle_byte_decoder_top;
   import erd_pkg::*;

   typedef logic [7:0] byte_list[$];

   // clock, reset and dut ports; the bench-driven ones are known from time zero
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;    // [7:0] data_byte
   logic             req_tlast  = 1'b0;     // last
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [47:0]      rsp_tdata;             // [7:0] run_value, [15:8] run_length,
                                            // [17:16] status, [41:18] produced_total
   logic [0:0]       rsp_tuser;             // [0] run_valid
   logic             rsp_tlast;             // done_res
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index  = REG_OUTPUT_LIMIT;
   logic [LIM_W-1:0] csr_data   = '0;

   // bench-side copy of the registers, at their reset values
   logic [LIM_W-1:0] limit_reg  = '0;
   logic [LIM_W-1:0] length_reg = '0;
   logic [7:0]       skip_reg   = 8'd2;

   // bench-side copy of the stream state
   logic [1:0]       dec_phase   = PH_LIT;
   logic [7:0]       held_byte   = 8'h00;
   logic [63:0]      out_count   = '0;
   logic [7:0]       header_seen = 8'h00;
   logic             halted      = 1'b0;

   item_type         bytes_waiting[$];      // items not yet offered
   result_type       runs_due[$];           // predicted results, oldest first

   int               fail_count     = 0;
   int               send_gap       = 0;
   int               hold_left      = 0;
   int               send_odds      = 0;    // 1 in n chance of a gap, 0 = never
   int               recv_odds      = 0;
   bit               long_hold_go   = 1'b0;
   bit               long_hold_done = 1'b0;

   escape_rle_byte_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // decode one compressed byte, advance the stream state, return its result
   function automatic result_type decode_byte(input logic [7:0] b, input logic fin);
      result_type  r;
      logic [63:0] lim;
      logic [63:0] n;
      logic [63:0] room;
      r   = '0;
      n   = '0;
      lim = 64'(limit_reg);
      if (header_seen < skip_reg) begin
         header_seen = header_seen + 8'd1;
      end else begin
         // a fresh token: stop for good once the limit has been met
         if (dec_phase != PH_VAL && dec_phase != PH_CNT) begin
            dec_phase = PH_LIT;
            if (lim != 0 && out_count >= lim) halted = 1'b1;
         end
         if (!halted) begin
            if (dec_phase == PH_VAL) begin
               held_byte = b;
               dec_phase = PH_CNT;
            end else if (dec_phase == PH_CNT) begin
               n = 64'(b);
               // clip the run to what is left of the limit
               if (lim != 0) begin
                  room = (out_count < lim) ? lim - out_count : 64'd0;
                  if (n > room) n = room;
               end
               r.run_value = held_byte;
               dec_phase   = PH_LIT;
            end else if (b == ESC_BYTE) begin
               dec_phase = PH_VAL;
            end else begin
               r.run_value = b;
               n           = 64'd1;
            end
         end
      end
      r.run_length = n[7:0];
      out_count    = out_count + n;
      if (out_count > 64'(CNT_MAX)) out_count = 64'(CNT_MAX);
      if (r.run_length == 8'd0) r.run_value = 8'h00;
      r.run_valid = (r.run_length != 8'd0);
      r.done_res  = fin;
      r.status    = ST_OK;
      if (fin) begin
         // ratio guard first, then a dangling escape, then a count off the limit
         if (lim != 0 && lim > 64'(length_reg) * 64'(RATIO_MAX)) r.status = ST_RATIO;
         else if (dec_phase == PH_VAL || dec_phase == PH_CNT) r.status = ST_TRUNC_ESC;
         else if (lim != 0 && out_count != lim) r.status = ST_SHORT;
      end
      r.produced_total = (out_count > 64'(TOT_MAX)) ? TOT_MAX : out_count[TOT_W-1:0];
      if (fin) begin
         dec_phase   = PH_LIT;
         held_byte   = 8'h00;
         out_count   = '0;
         header_seen = 8'h00;
         halted      = 1'b0;
      end
      return r;
   endfunction

   function automatic string run_text(input result_type r);
      return $sformatf("valid=%0d value=%02h length=%0d done=%0d status=%0d total=%06h",
                       r.run_valid, r.run_value, r.run_length, r.done_res, r.status,
                       r.produced_total);
   endfunction

   // driver: takes items from the queue, with random gaps
   always @(posedge clock) begin : req_driver
      item_type   nxt;
      result_type pred;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         // accepted item: predict its result now
         if (req_tvalid && req_tready) begin
            pred = decode_byte(req_tdata, req_tlast);
            runs_due.insert(runs_due.size(), pred);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
               send_gap   <= $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (bytes_waiting.size() != 0) begin
               nxt        = bytes_waiting.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data_byte;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.run_valid      = rsp_tuser[0];
            got.run_value      = rsp_tdata[7:0];
            got.run_length     = rsp_tdata[15:8];
            got.status         = rsp_tdata[17:16];
            got.produced_total = rsp_tdata[41:18];
            got.done_res       = rsp_tlast;
            if (runs_due.size() == 0) begin
               if (fail_count < 10) $display("result with no item pending: %s", run_text(got));
               fail_count++;
            end else begin
               want = runs_due.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("result mismatch\n  expected %s\n  actual   %s",
                              run_text(want), run_text(got));
                  fail_count++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (long_hold_go && !long_hold_done) begin
            hold_left      <= 120;
            long_hold_done <= 1'b1;
            rsp_tready     <= 1'b0;
         end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
            hold_left  <= $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // wait until every item has been taken and every result has come back
   task automatic wait_idle();
      while (bytes_waiting.size() != 0 || req_tvalid || runs_due.size() != 0)
         @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
      wait_idle();
      repeat (3) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_OUTPUT_LIMIT: limit_reg  = val;
         REG_INPUT_LENGTH: length_reg = val;
         REG_SKIP_COUNT:   skip_reg   = val[7:0];
         default:          ;
      endcase
      @(negedge clock);
   endtask

   // queue one stream, last on its final byte; a split stream pauses halfway
   // until the block has drained
   task automatic send_stream(input byte_list s, input bit split);
      int       k;
      int       cut;
      item_type it;
      cut = split ? s.size() / 2 : -1;
      for (k = 0; k < s.size(); k++) begin
         if (k == cut && k != 0) wait_idle();
         it.data_byte = s[k];
         it.last      = (k == s.size() - 1);
         bytes_waiting.insert(bytes_waiting.size(), it);
      end
   endtask

   // mostly well-formed streams; a few are header only, noise or cut short
   function automatic byte_list random_stream(input int hdr, input int ntok);
      byte_list   s;
      int         k;
      int         form;
      logic [7:0] lit;
      form = $urandom_range(0, 15);
      for (k = 0; k < hdr; k++) s.insert(s.size(), 8'($urandom));
      if (form == 0 && hdr != 0) return s;
      for (k = 0; k < ntok; k++) begin
         if (form == 1) begin
            s.insert(s.size(), ($urandom_range(0, 3) == 0) ? ESC_BYTE : 8'($urandom));
         end else if ($urandom_range(0, 2) == 0) begin
            s.insert(s.size(), ESC_BYTE);
            s.insert(s.size(), ($urandom_range(0, 7) == 0) ? ESC_BYTE : 8'($urandom));
            case ($urandom_range(0, 5))
               0:       s.insert(s.size(), 8'h00);
               1:       s.insert(s.size(), 8'hff);
               default: s.insert(s.size(), 8'($urandom));
            endcase
         end else begin
            lit = 8'($urandom);
            if (lit == ESC_BYTE) lit = 8'hfd;
            s.insert(s.size(), lit);
         end
      end
      // stream ends inside an escape
      if (form == 2 || form == 3) s.insert(s.size(), ESC_BYTE);
      if (form == 3) s.insert(s.size(), 8'($urandom));
      return s;
   endfunction

   initial begin : stimulus
      byte_list         s;
      int               item_total;
      int               grp;
      int               k;
      int               n;
      logic [LIM_W-1:0] lim_pick;
      logic [LIM_W-1:0] len_pick;
      logic [7:0]       skip_pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_odds = 5;
      recv_odds = 5;

      // directed, reset registers: no limit, two header bytes
      // literals at both extremes, a zero-count run, an escaped escape value
      s = '{8'h00, 8'hff, 8'h00, 8'hff, ESC_BYTE, 8'h55, 8'h00,
            ESC_BYTE, ESC_BYTE, 8'hff, 8'h7f};
      send_stream(s, 1'b0);
      // header-only stream with no limit
      s = '{8'h11};
      send_stream(s, 1'b0);
      // stream ends while the count byte is still due
      s = '{8'h01, 8'h02, ESC_BYTE, 8'h33};
      send_stream(s, 1'b0);

      // limit of 10: clipping, then an escape after the limit is ignored
      write_reg(REG_OUTPUT_LIMIT, LIM_W'(10));
      write_reg(REG_INPUT_LENGTH, LIM_W'(1));
      write_reg(REG_SKIP_COUNT, LIM_W'(1));
      s = '{8'h99, 8'h41, ESC_BYTE, 8'h42, 8'h05, ESC_BYTE, 8'h43, 8'hff, ESC_BYTE, 8'h44};
      send_stream(s, 1'b0);
      // all header with a limit set: short output
      s = '{8'h50};
      send_stream(s, 1'b0);

      // ratio guard wins over a dangling escape
      write_reg(REG_OUTPUT_LIMIT, '1);
      write_reg(REG_INPUT_LENGTH, '0);
      s = '{8'h77, 8'h01, ESC_BYTE};
      send_stream(s, 1'b0);

      // random part, registers changed between groups of streams
      item_total = 0;
      grp        = 0;
      while (item_total < 1000) begin
         if (grp == 0) begin
            lim_pick  = '1;
            len_pick  = '1;
            skip_pick = 8'hff;
         end else begin
            case ($urandom_range(0, 5))
               0:       lim_pick = '0;
               1, 2:    lim_pick = LIM_W'($urandom_range(1, 60));
               3:       lim_pick = LIM_W'($urandom_range(1, 400));
               4:       lim_pick = LIM_W'($urandom);
               default: lim_pick = '1;
            endcase
            case ($urandom_range(0, 6))
               0:       len_pick = '0;
               1:       len_pick = LIM_W'($urandom_range(1, 3));
               2:       len_pick = LIM_W'($urandom);
               3:       len_pick = lim_pick / 1000;             // just under the guard
               4:       len_pick = (lim_pick + 999) / 1000;     // exactly on the guard
               default: len_pick = '1;
            endcase
            case ($urandom_range(0, 11))
               0, 1, 2, 3: skip_pick = 8'h00;
               11:         skip_pick = 8'($urandom_range(5, 40));
               default:    skip_pick = 8'($urandom_range(1, 4));
            endcase
         end
         write_reg(REG_OUTPUT_LIMIT, lim_pick);
         write_reg(REG_INPUT_LENGTH, len_pick);
         write_reg(REG_SKIP_COUNT, LIM_W'(skip_pick));
         case ($urandom_range(0, 2))
            0:       send_odds = 0;
            1:       send_odds = 3;
            default: send_odds = 6;
         endcase
         case ($urandom_range(0, 2))
            0:       recv_odds = 0;
            1:       recv_odds = 3;
            default: recv_odds = 6;
         endcase
         // the full header stream runs alone
         n = (grp == 0) ? 1 : $urandom_range(1, 4);
         for (k = 0; k < n; k++) begin
            if (grp == 2 && k == 0) begin
               // receiver holds off while a long stream keeps coming
               send_odds    = 0;
               long_hold_go = 1'b1;
               do s = random_stream(skip_reg, 60); while (s.size() < 8);
            end else begin
               s = random_stream(skip_reg, $urandom_range(1, 24));
            end
            item_total += s.size();
            send_stream(s, $urandom_range(0, 7) == 0);
         end
         grp++;
      end

      // last part, no idling: back-to-back runs of the longest count
      send_odds = 0;
      recv_odds = 0;
      write_reg(REG_OUTPUT_LIMIT, '0);
      write_reg(REG_SKIP_COUNT, '0);
      repeat (12) @(negedge clock);
      s.delete();
      for (k = 0; k < 6; k++) begin
         s.insert(s.size(), ESC_BYTE);
         s.insert(s.size(), 8'($urandom));
         s.insert(s.size(), 8'hff);
      end
      s.insert(s.size(), 8'h3c);
      s.insert(s.size(), ESC_BYTE);
      s.insert(s.size(), 8'h10);
      s.insert(s.size(), 8'h20);
      send_stream(s, 1'b0);

      wait_idle();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("** escape_rle_byte_decoder_top: PASSED **");
      end else begin
         $display("** escape_rle_byte_decoder_top: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #20000000;
      $display("** escape_rle_byte_decoder_top: FAILED **");
      $finish;
   end

endmodule
